// ----- rtl/core/eg2g_pkg.sv -----
// ----------------------------------------------------------------------------
// eg2g_pkg
// Shared types, constants and the cordic arctangent table for the
// equatorial to galactic coordinate transform.
// ----------------------------------------------------------------------------
package eg2g_pkg;

  localparam int DW   = 34;
  localparam int FRAC = 30;

  typedef logic signed [DW-1:0] data_t;

  localparam data_t INV_GAIN = 34'sd652032874;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

  localparam int RIGHT_ANGLE_DEG = 90;
  localparam int DEG_PER_TURN    = 360;
  localparam logic signed [31:0] LAT_LIMIT = 32'(RIGHT_ANGLE_DEG * 4194304);

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POLE_RA    = 2'd0;
  localparam cfg_idx_t CFG_POLE_DEC   = 2'd1;
  localparam cfg_idx_t CFG_LON_OFFSET = 2'd2;

  // atan(2^-i) as a binary angle of ab bits
  function automatic logic [63:0] atan_ba(input int ab, input int i);
    logic [63:0]  r;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [63:0]  b;
    int           e;
    int           s;
    r = '0;
    if (i == 0) begin
      return 64'd1 << (ab - 3);
    end
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) r = r - term;
        else r = r + term;
      end
    end
    prod = {64'd0, r} * {64'd0, INV_TWO_PI_Q64};
    b = prod[127:64];
    s = 62 - ab;
    return (b + (64'd1 << (s - 1))) >> s;
  endfunction

endpackage

// ----- rtl/core/eg2g_in_if.sv -----
// ----------------------------------------------------------------------------
// eg2g_in_if
// Star position channel: right ascension and declination beats.
// ----------------------------------------------------------------------------
interface eg2g_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] ra_angle;
  logic signed [31:0] dec_angle;

  modport source (output valid, output ra_angle, output dec_angle, input ready);
  modport sink (input valid, input ra_angle, input dec_angle, output ready);
endinterface

// ----- rtl/core/eg2g_out_if.sv -----
// ----------------------------------------------------------------------------
// eg2g_out_if
// Galactic coordinate channel: longitude and latitude beats.
// ----------------------------------------------------------------------------
interface eg2g_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lon_deg;
  logic signed [29:0] lat_deg;

  modport source (output valid, output lon_deg, output lat_deg, input ready);
  modport sink (input valid, input lon_deg, input lat_deg, output ready);
endinterface

// ----- rtl/core/equatorial_to_galactic_top.sv -----
// ----------------------------------------------------------------------------
// equatorial_to_galactic_top
// Converts star positions from equatorial to galactic coordinates.
//
// in_chan carries one star per beat (ra_angle, dec_angle as binary angles);
// out_chan returns one beat with lon_deg in degrees, Q9.22, and lat_deg in degrees, Q7.22.
// The cfg port writes pole_ra, pole_dec and lon_offset; write them only
// while no beat is in flight.
// Three unrolled cordic chains run in series (sine/cosine, three wide;
// longitude vectoring; latitude vectoring), together with twelve stages
// of range reduction, products, gain correction and degree scaling.
// Throughput is one beat per cycle while out_chan is not stalled.
// The whole pipeline advances together; when out_chan is stalled with a
// beat held, in_chan.ready drops and every stage holds its contents.
// Reset clears the valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module equatorial_to_galactic_top #(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  eg2g_in_if.sink                      in_chan,
  eg2g_out_if.source                   out_chan,
  input  logic                         cfg_we,
  input  eg2g_pkg::cfg_idx_t           cfg_idx,
  input  logic [31:0]                  cfg_data
);

  localparam int AB = ANGLE_BITS;
  localparam int ZW = AB + 2;
  localparam int DEGW = AB + 10;

  typedef logic signed [ZW-1:0] zang_t;
  typedef logic signed [AB-1:0] ang_t;

  localparam zang_t QUARTER = zang_t'(1) <<< (AB - 2);
  localparam zang_t HALF    = zang_t'(1) <<< (AB - 1);

  logic [31:0]        pole_ra_r;
  logic [31:0]        pole_dec_r;
  logic signed [31:0] lon_offset_r;

  logic adv;
  logic out_valid_r;

  assign adv = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_ra_r    <= '0;
      pole_dec_r   <= '0;
      lon_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        eg2g_pkg::CFG_POLE_RA:    pole_ra_r    <= cfg_data;
        eg2g_pkg::CFG_POLE_DEC:   pole_dec_r   <= cfg_data;
        eg2g_pkg::CFG_LON_OFFSET: lon_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scale 32-bit angles to AB bits
  function automatic ang_t scale32(input logic [31:0] v);
    logic [AB+31:0] t;
    t = {v, {AB{1'b0}}};
    return t[AB+31 -: AB];
  endfunction

  function automatic zang_t widen(input ang_t a);
    return zang_t'(a);
  endfunction

  // ---- stage 0: range reduction for the three sine/cosine angles
  zang_t a_dec, a_pole, a_h;
  logic [31:0] h_raw;
  assign h_raw  = in_chan.ra_angle - pole_ra_r;
  assign a_dec  = widen(scale32(in_chan.dec_angle));
  assign a_pole = widen(scale32(pole_dec_r));
  assign a_h    = widen(scale32(h_raw));

  logic  v0_r;
  zang_t z_dec_r, z_pole_r, z_h_r;
  logic  n_dec_r, n_pole_r, n_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_dec_r  <= (a_dec > QUARTER) || (a_dec < -QUARTER);
      n_pole_r <= (a_pole > QUARTER) || (a_pole < -QUARTER);
      n_h_r    <= (a_h > QUARTER) || (a_h < -QUARTER);
      z_dec_r  <= (a_dec > QUARTER) ? a_dec - HALF :
                  (a_dec < -QUARTER) ? a_dec + HALF : a_dec;
      z_pole_r <= (a_pole > QUARTER) ? a_pole - HALF :
                  (a_pole < -QUARTER) ? a_pole + HALF : a_pole;
      z_h_r    <= (a_h > QUARTER) ? a_h - HALF :
                  (a_h < -QUARTER) ? a_h + HALF : a_h;
    end
  end

  // ---- sine/cosine chains
  logic            sc_vld, sc_vld_p, sc_vld_h;
  eg2g_pkg::data_t c_dec, s_dec, c_pole, s_pole, c_h, s_h;
  zang_t           zr_dec, zr_pole, zr_h;
  logic            sn_dec, sn_pole, sn_h;

  eg2g_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR(1'b0),
    .SIDE_W(1)) u_sc_dec (
    .clk, .rst_n, .en(adv), .vld_i(v0_r), .x_i(eg2g_pkg::INV_GAIN), .y_i('0),
    .z_i(z_dec_r), .side_i(n_dec_r), .vld_o(sc_vld), .x_o(c_dec), .y_o(s_dec),
    .z_o(zr_dec), .side_o(sn_dec));

  eg2g_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR(1'b0),
    .SIDE_W(1)) u_sc_pole (
    .clk, .rst_n, .en(adv), .vld_i(v0_r), .x_i(eg2g_pkg::INV_GAIN), .y_i('0),
    .z_i(z_pole_r), .side_i(n_pole_r), .vld_o(sc_vld_p), .x_o(c_pole),
    .y_o(s_pole), .z_o(zr_pole), .side_o(sn_pole));

  eg2g_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR(1'b0),
    .SIDE_W(1)) u_sc_h (
    .clk, .rst_n, .en(adv), .vld_i(v0_r), .x_i(eg2g_pkg::INV_GAIN), .y_i('0),
    .z_i(z_h_r), .side_i(n_h_r), .vld_o(sc_vld_h), .x_o(c_h), .y_o(s_h),
    .z_o(zr_h), .side_o(sn_h));

  // ---- stage 1: quadrant fix
  logic            v1_r;
  eg2g_pkg::data_t cd_r, sd_r, cp_r, sp_r, ch_r, sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= sc_vld & sc_vld_p & sc_vld_h & (zr_dec[0] | ~zr_dec[0])
              & (zr_pole[0] | ~zr_pole[0]) & (zr_h[0] | ~zr_h[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_r <= sn_dec ? -c_dec : c_dec;
      sd_r <= sn_dec ? -s_dec : s_dec;
      cp_r <= sn_pole ? -c_pole : c_pole;
      sp_r <= sn_pole ? -s_pole : s_pole;
      ch_r <= sn_h ? -c_h : c_h;
      sh_r <= sn_h ? -s_h : s_h;
    end
  end

  // ---- stage 2: first products
  typedef logic signed [2*eg2g_pkg::DW-1:0] prod_t;
  prod_t p_cdch, p_cdsh;
  assign p_cdch = cd_r * ch_r;
  assign p_cdsh = cd_r * sh_r;

  logic            v2_r;
  eg2g_pkg::data_t w_r, xv2_r, cp2_r, sp2_r;
  prod_t           psp_r, pcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r   <= eg2g_pkg::data_t'(p_cdch >>> eg2g_pkg::FRAC);
      xv2_r <= eg2g_pkg::data_t'(p_cdsh >>> eg2g_pkg::FRAC);
      psp_r <= sd_r * sp_r;
      pcp_r <= sd_r * cp_r;
      cp2_r <= cp_r;
      sp2_r <= sp_r;
    end
  end

  // ---- stage 3: second products
  logic            v3_r;
  prod_t           pwcp_r, pwsp_r, psp3_r, pcp3_r;
  eg2g_pkg::data_t xv3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pwcp_r <= w_r * cp2_r;
      pwsp_r <= w_r * sp2_r;
      psp3_r <= psp_r;
      pcp3_r <= pcp_r;
      xv3_r  <= xv2_r;
    end
  end

  // ---- stage 4: sums
  logic signed [2*eg2g_pkg::DW:0] sum_sb, sum_yv;
  assign sum_sb = (2*eg2g_pkg::DW+1)'(psp3_r) + (2*eg2g_pkg::DW+1)'(pwcp_r);
  assign sum_yv = (2*eg2g_pkg::DW+1)'(pcp3_r) - (2*eg2g_pkg::DW+1)'(pwsp_r);

  logic            v4_r;
  eg2g_pkg::data_t sb_r, yv_r, xv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r <= eg2g_pkg::data_t'(sum_sb >>> eg2g_pkg::FRAC);
      yv_r <= eg2g_pkg::data_t'(sum_yv >>> eg2g_pkg::FRAC);
      xv_r <= xv3_r;
    end
  end

  // ---- stage 5: longitude vectoring setup
  logic            v5_r;
  eg2g_pkg::data_t lx_r, ly_r;
  zang_t           lz_r;
  logic            lzero_r;
  eg2g_pkg::data_t sb5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lzero_r <= (xv_r == '0) && (yv_r == '0);
      lx_r    <= (xv_r < 0) ? -xv_r : xv_r;
      ly_r    <= (xv_r < 0) ? -yv_r : yv_r;
      lz_r    <= (xv_r < 0) ? HALF : '0;
      sb5_r   <= sb_r;
    end
  end

  logic                                lv_vld;
  eg2g_pkg::data_t                     lv_x, lv_y;
  zang_t                               lv_z;
  logic [eg2g_pkg::DW:0]               lv_side;

  eg2g_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR(1'b1),
    .SIDE_W(eg2g_pkg::DW + 1)) u_vec_lon (
    .clk, .rst_n, .en(adv), .vld_i(v5_r), .x_i(lx_r), .y_i(ly_r), .z_i(lz_r),
    .side_i({lzero_r, sb5_r}), .vld_o(lv_vld), .x_o(lv_x), .y_o(lv_y),
    .z_o(lv_z), .side_o(lv_side));

  // ---- stage 6: longitude angle and length
  logic            v6_r;
  ang_t            lon_ang6_r;
  eg2g_pkg::data_t k_r, sb6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= lv_vld & (lv_y[0] | ~lv_y[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lon_ang6_r <= lv_side[eg2g_pkg::DW] ? '0 : ang_t'(lv_z[AB-1:0]);
      k_r        <= lv_side[eg2g_pkg::DW] ? '0 : lv_x;
      sb6_r      <= lv_side[eg2g_pkg::DW-1:0];
    end
  end

  // ---- stage 7: gain correction
  prod_t p_hyp;
  assign p_hyp = k_r * eg2g_pkg::INV_GAIN;

  logic            v7_r;
  eg2g_pkg::data_t hyp_r, sb7_r;
  ang_t            lon_ang7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hyp_r      <= eg2g_pkg::data_t'(p_hyp >>> eg2g_pkg::FRAC);
      sb7_r      <= sb6_r;
      lon_ang7_r <= lon_ang6_r;
    end
  end

  // ---- stage 8: latitude vectoring setup
  logic            v8_r;
  eg2g_pkg::data_t bx_r, by_r;
  zang_t           bz_r;
  logic            bzero_r;
  ang_t            lon_ang8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bzero_r    <= (hyp_r == '0) && (sb7_r == '0);
      bx_r       <= (hyp_r < 0) ? -hyp_r : hyp_r;
      by_r       <= (hyp_r < 0) ? -sb7_r : sb7_r;
      bz_r       <= (hyp_r < 0) ? HALF : '0;
      lon_ang8_r <= lon_ang7_r;
    end
  end

  logic            bv_vld;
  eg2g_pkg::data_t bv_x, bv_y;
  zang_t           bv_z;
  logic [AB:0]     bv_side;

  eg2g_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR(1'b1),
    .SIDE_W(AB + 1)) u_vec_lat (
    .clk, .rst_n, .en(adv), .vld_i(v8_r), .x_i(bx_r), .y_i(by_r), .z_i(bz_r),
    .side_i({bzero_r, lon_ang8_r}), .vld_o(bv_vld), .x_o(bv_x), .y_o(bv_y),
    .z_o(bv_z), .side_o(bv_side));

  // ---- stage 9: latitude angle
  logic v9_r;
  ang_t lat_ang_r, lon_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (adv) begin
      v9_r <= bv_vld & (bv_x[0] | ~bv_x[0]) & (bv_y[0] | ~bv_y[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_ang_r <= bv_side[AB] ? '0 : ang_t'(bv_z[AB-1:0]);
      lon_ang_r <= ang_t'(bv_side[AB-1:0]);
    end
  end

  // ---- stage 10: binary angle to degrees, Q22
  logic signed [DEGW-1:0] lon_v, lat_v;
  logic signed [31:0]     lon_d, lat_d;
  assign lon_v = DEGW'(lon_ang_r) * DEGW'(eg2g_pkg::DEG_PER_TURN);
  assign lat_v = DEGW'(lat_ang_r) * DEGW'(eg2g_pkg::DEG_PER_TURN);

  if (AB > 22) begin : g_deg_shr
    localparam logic signed [DEGW-1:0] RND = DEGW'(1) <<< (AB - 23);
    logic signed [DEGW-1:0] lon_s, lat_s;
    assign lon_s = (lon_v + RND) >>> (AB - 22);
    assign lat_s = (lat_v + RND) >>> (AB - 22);
    assign lon_d = lon_s[31:0];
    assign lat_d = lat_s[31:0];
  end else begin : g_deg_shl
    logic signed [31:0] lon_e, lat_e;
    assign lon_e = 32'(lon_v);
    assign lat_e = 32'(lat_v);
    assign lon_d = lon_e <<< (22 - AB);
    assign lat_d = lat_e <<< (22 - AB);
  end

  logic               v10_r;
  logic signed [31:0] lon_d_r, lat_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (adv) begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lon_d_r <= lon_d;
      lat_d_r <= lat_d;
    end
  end

  // ---- stage 11: offset, saturation, output register
  logic signed [32:0] lon_sum;
  logic signed [31:0] lon_nxt;
  logic signed [31:0] lat_nxt;
  assign lon_sum = 33'(lon_d_r) + 33'(lon_offset_r);

  always_comb begin
    priority if (lon_sum > 33'sh0_7FFF_FFFF) begin
      lon_nxt = 32'sh7FFF_FFFF;
    end else if (lon_sum < -33'sh0_8000_0000) begin
      lon_nxt = 32'sh8000_0000;
    end else begin
      lon_nxt = lon_sum[31:0];
    end
    priority if (lat_d_r > eg2g_pkg::LAT_LIMIT) begin
      lat_nxt = eg2g_pkg::LAT_LIMIT;
    end else if (lat_d_r < -eg2g_pkg::LAT_LIMIT) begin
      lat_nxt = -eg2g_pkg::LAT_LIMIT;
    end else begin
      lat_nxt = lat_d_r;
    end
  end

  logic signed [31:0] lon_out_r;
  logic signed [29:0] lat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lon_out_r <= lon_nxt;
      lat_out_r <= lat_nxt[29:0];
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.lon_deg = lon_out_r;
  assign out_chan.lat_deg = lat_out_r;

endmodule

// ----- rtl/core/eg2g_cordic.sv -----
// ----------------------------------------------------------------------------
// eg2g_cordic
// Unrolled cordic, one registered micro-rotation per stage, rotation or
// vectoring mode, with a sideband carried alongside.
// ----------------------------------------------------------------------------
module eg2g_cordic #(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 24,
  parameter bit VECTOR        = 1'b0,
  parameter int SIDE_W        = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  eg2g_pkg::data_t                   x_i,
  input  eg2g_pkg::data_t                   y_i,
  input  logic signed [ANGLE_BITS+1:0]      z_i,
  input  logic        [SIDE_W-1:0]          side_i,
  output logic                              vld_o,
  output eg2g_pkg::data_t                   x_o,
  output eg2g_pkg::data_t                   y_o,
  output logic signed [ANGLE_BITS+1:0]      z_o,
  output logic        [SIDE_W-1:0]          side_o
);

  localparam int ZW = ANGLE_BITS + 2;

  logic                 vld_r  [CORDIC_STAGES];
  eg2g_pkg::data_t      x_r    [CORDIC_STAGES];
  eg2g_pkg::data_t      y_r    [CORDIC_STAGES];
  logic signed [ZW-1:0] z_r    [CORDIC_STAGES];
  logic [SIDE_W-1:0]    side_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [63:0] TAB64 = eg2g_pkg::atan_ba(ANGLE_BITS, i);
    localparam logic signed [ZW-1:0] TAB = TAB64[ZW-1:0];

    logic                 vld_in;
    eg2g_pkg::data_t      x_in;
    eg2g_pkg::data_t      y_in;
    logic signed [ZW-1:0] z_in;
    logic [SIDE_W-1:0]    side_in;
    logic                 pos;
    eg2g_pkg::data_t      x_nxt;
    eg2g_pkg::data_t      y_nxt;
    logic signed [ZW-1:0] z_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign x_in    = x_i;
      assign y_in    = y_i;
      assign z_in    = z_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      pos = VECTOR ? (y_in < 0) : (z_in >= 0);
      if (pos) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - TAB;
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + TAB;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[CORDIC_STAGES-1];
  assign x_o    = x_r[CORDIC_STAGES-1];
  assign y_o    = y_r[CORDIC_STAGES-1];
  assign z_o    = z_r[CORDIC_STAGES-1];
  assign side_o = side_r[CORDIC_STAGES-1];

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for equatorial_to_galactic_top. Star positions are streamed
// through the in channel with random gaps while the out channel stalls at
// random, including one long hold-off. Each accepted beat is run through a
// cordic-based galactic transform in the testbench, and every output beat
// is checked field by field against the oldest prediction. The pole and the
// longitude offset are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STAGES      = 24;
  localparam int PIPE_CYCLES = 12 + 3 * STAGES;
  localparam longint CORDIC_K = 652032874;
  localparam longint LAT_MAX  = 377487360;

  typedef struct packed {
    logic        [31:0] ra;
    logic signed [31:0] dec;
  } star_t;

  typedef struct packed {
    logic signed [31:0] lon;
    logic signed [29:0] lat;
  } gal_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  eg2g_pkg::cfg_idx_t cfg_idx;
  logic [31:0] cfg_data;

  eg2g_in_if  in_if ();
  eg2g_out_if out_if ();

  equatorial_to_galactic_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  logic [31:0] pole_ra_q;
  logic [31:0] pole_dec_q;
  logic [31:0] lon_offset_q;
  longint      atan_steps[STAGES];

  star_t star_q[$];
  gal_t  gal_expected_q[$];
  int    n_errors;
  int    n_accepted;
  int    in_gap;
  int    out_hold;
  bit    holdoff_done;

  // atan(2^-i) as a 32-bit binary angle
  function automatic void build_atan_steps();
    logic [63:0]  acc;
    logic [127:0] prod;
    int           e;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        atan_steps[i] = 64'd1 << 29;
      end else begin
        acc = 0;
        for (int k = 0; k < 40; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            if (k % 2 == 1) acc -= (64'd1 << (62 - e)) / (2 * k + 1);
            else acc += (64'd1 << (62 - e)) / (2 * k + 1);
          end
        end
        prod = {64'd0, acc} * 128'h28BE60DB9391054A;
        atan_steps[i] = longint'((prod[127:64] + (64'd1 << 29)) >> 30);
      end
    end
  endfunction

  function automatic longint wrap32(longint v);
    logic signed [31:0] t;
    t = v[31:0];
    return longint'(t);
  endfunction

  function automatic void rotate_unit(logic [31:0] ang, output longint c, output longint s);
    longint a, x, y, dx, dy;
    bit     flip;
    a = wrap32(longint'(ang));
    x = CORDIC_K;
    y = 0;
    flip = 0;
    if (a > (64'sd1 <<< 30)) begin
      a -= 64'sd1 <<< 31;
      flip = 1;
    end else if (a < -(64'sd1 <<< 30)) begin
      a += 64'sd1 <<< 31;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_steps[i];
      end else begin
        x += dx; y -= dy; a += atan_steps[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void vector_angle(longint xi, longint yi, output longint ang,
                                       output longint mag);
    longint x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd1 <<< 31;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    ang = wrap32(z);
    mag = x;
  endfunction

  function automatic longint binang_to_deg(longint a);
    return (a * 360 + 512) >>> 10;
  endfunction

  function automatic gal_t galactic_of(star_t s);
    longint cd, sd, cp, sp, ch, sh, w, sin_b, yv, xv;
    longint lon_ang, k, hyp, lat_ang, spare, lon, lat;
    gal_t   g;
    rotate_unit(s.dec, cd, sd);
    rotate_unit(pole_dec_q, cp, sp);
    rotate_unit(s.ra - pole_ra_q, ch, sh);
    w     = (cd * ch) >>> 30;
    sin_b = (sd * sp + w * cp) >>> 30;
    yv    = (sd * cp - w * sp) >>> 30;
    xv    = (cd * sh) >>> 30;
    vector_angle(xv, yv, lon_ang, k);
    hyp = (k * CORDIC_K) >>> 30;
    vector_angle(hyp, sin_b, lat_ang, spare);
    lon = binang_to_deg(lon_ang) + wrap32(longint'(lon_offset_q));
    if (lon > 64'sd2147483647) lon = 64'sd2147483647;
    if (lon < -64'sd2147483648) lon = -64'sd2147483648;
    lat = binang_to_deg(lat_ang);
    if (lat > LAT_MAX) lat = LAT_MAX;
    if (lat < -LAT_MAX) lat = -LAT_MAX;
    g.lon = lon[31:0];
    g.lat = lat[29:0];
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // source side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 0;
      in_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        gal_expected_q.push_back(galactic_of({in_if.ra_angle, in_if.dec_angle}));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_if.valid <= 0;
        end else if (star_q.size() > 0) begin
          star_t s;
          s = star_q.pop_front();
          in_if.valid     <= 1;
          in_if.ra_angle  <= s.ra;
          in_if.dec_angle <= s.dec;
          in_gap <= pick_gap();
        end else begin
          in_if.valid <= 0;
        end
      end
    end
  end

  // sink side with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 0;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_if.ready <= 0;
    end else if (!holdoff_done && n_accepted > 360) begin
      holdoff_done <= 1;
      out_hold <= 400;
      out_if.ready <= 0;
    end else if (n_accepted > 500 && n_accepted < 600) begin
      out_if.ready <= 1;
    end else begin
      out_hold <= pick_gap();
      out_if.ready <= 1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (gal_expected_q.size() == 0) begin
        $error("unexpected beat lon_deg=%0d lat_deg=%0d", out_if.lon_deg, out_if.lat_deg);
        n_errors++;
      end else begin
        gal_t e;
        e = gal_expected_q.pop_front();
        if (out_if.lon_deg !== e.lon) begin
          $error("lon_deg expected %0d actual %0d", e.lon, out_if.lon_deg);
          n_errors++;
        end
        if (out_if.lat_deg !== e.lat) begin
          $error("lat_deg expected %0d actual %0d", e.lat, out_if.lat_deg);
          n_errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (star_q.size() > 0 || in_if.valid || gal_expected_q.size() > 0) @(negedge clk);
    repeat (PIPE_CYCLES + 10) @(posedge clk);
  endtask

  task automatic write_reg(eg2g_pkg::cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we   <= 1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      eg2g_pkg::CFG_POLE_RA:  pole_ra_q = val;
      eg2g_pkg::CFG_POLE_DEC: pole_dec_q = val;
      default:                lon_offset_q = val;
    endcase
  endtask

  task automatic set_frame(logic [31:0] ra, logic [31:0] dec, logic [31:0] off);
    wait_idle();
    write_reg(eg2g_pkg::CFG_POLE_RA, ra);
    write_reg(eg2g_pkg::CFG_POLE_DEC, dec);
    write_reg(eg2g_pkg::CFG_LON_OFFSET, off);
  endtask

  task automatic add_star(logic [31:0] ra, logic [31:0] dec);
    star_q.push_back({ra, dec});
  endtask

  task automatic add_random_stars(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        add_star($urandom, 32'($urandom_range(32'h80000000, 0)) - 32'h40000000);
      else
        add_star($urandom, $urandom);
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = eg2g_pkg::CFG_POLE_RA;
    cfg_data = 0;
    in_if.valid = 0;
    in_if.ra_angle = 0;
    in_if.dec_angle = 0;
    out_if.ready = 0;
    n_errors = 0;
    n_accepted = 0;
    holdoff_done = 0;
    pole_ra_q = 0;
    pole_dec_q = 0;
    lon_offset_q = 0;
    build_atan_steps();
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // reset frame: poles, equator, out-of-range declinations
    add_star(0, 0);
    add_star(32'hFFFFFFFF, 0);
    add_star(0, 32'h40000000);
    add_star(0, 32'hC0000000);
    add_star(32'h80000000, 32'h40000000);
    add_star(32'h40000000, 0);
    add_star(32'hC0000000, 0);
    add_star(32'h80000000, 0);
    add_star(32'h7FFFFFFF, 32'h7FFFFFFF);
    add_star(32'h12345678, 32'h80000000);
    add_star(32'hFFFFFFFF, 32'hFFFFFFFF);
    add_star(32'h00000001, 32'h3FFFFFFF);
    add_random_stars(150);

    set_frame(32'h8925C8E7, 32'h1F7B8C21, 32'h1D3C0000);
    add_star(32'h8925C8E7, 32'h1F7B8C21);
    add_star(32'h0925C8E7, 32'hE0847398);
    add_random_stars(170);

    set_frame(32'hFFFFFFFF, 32'h40000000, 32'd1509949440);
    add_star(0, 32'h40000000);
    add_star(32'h55555555, 32'hC0000000);
    add_random_stars(170);

    set_frame(0, 32'hC0000000, -32'd1509949440);
    add_star(0, 32'hC0000000);
    add_star(32'hFFFFFFFF, 32'h40000000);
    add_random_stars(170);

    set_frame($urandom, $urandom, $urandom);
    add_random_stars(170);

    set_frame($urandom, 32'($urandom_range(32'h80000000, 0)) - 32'h40000000,
              32'($urandom_range(32'd3019898880, 0)) - 32'd1509949440);
    add_random_stars(170);

    wait_idle();
    if (n_errors == 0) begin
      $display("equatorial_to_galactic_top verification clean");
    end else begin
      $display("equatorial_to_galactic_top verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("equatorial_to_galactic_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/eg2g_pkg.sv
rtl/core/eg2g_in_if.sv
rtl/core/eg2g_out_if.sv
rtl/core/eg2g_cordic.sv
rtl/core/equatorial_to_galactic_top.sv
sim/tb_top.sv
